FILE: rtl/core/ptb_pkg.sv
// ptb_pkg: shared constants, codes and types of the page table builder
// no dependencies; used by the channel interfaces, ptb_entry_eval and page_table_builder
package ptb_pkg;

  localparam int POOL_PAGES_DEF = 16;
  localparam int VA_W   = 64;
  localparam int PA_W   = 52;
  localparam int LEN_W  = 41;
  localparam int FLG_W  = 12;
  localparam int ST_W   = 3;
  localparam int NFP_W  = 5;
  localparam int FRM_W  = 40;   // address bits 51..12
  localparam int IDX_W  = 9;    // index bits of a table page of 512 entries
  localparam int CUR_W  = 54;   // physical cursor, holds start plus length
  localparam int OFF_W  = 8;    // page offset of a followed pointer

  // request kinds
  localparam logic [1:0] REQ_4K    = 2'd0;
  localparam logic [1:0] REQ_2M    = 2'd1;
  localparam logic [1:0] REQ_RANGE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_MISALIGNED = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_PDPT    = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_PD      = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_PT      = 3'd4;
  localparam logic [ST_W-1:0] ST_DIFFERENT  = 3'd5;

  // table levels
  localparam logic [1:0] LVL_PML4 = 2'd3;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PT   = 2'd0;

  // entry bits
  localparam int E_PRESENT = 0;
  localparam int E_WRITE   = 1;
  localparam int E_LARGE   = 7;
  localparam int E_NOEXEC  = 63;

  // verdict on one table entry
  typedef struct packed {
    logic             present;
    logic             refuse;     // large entry met while walking to a 4K leaf
    logic             off_ok;     // pointer names a pool page
    logic [OFF_W-1:0] off;
    logic             leaf_same;  // present leaf maps the requested frame
  } ptb_eval_t;

endpackage

FILE: rtl/core/ptb_if.sv
// ptb_req_if and ptb_rsp_if: valid/ready channels of the page table builder
// depends on ptb_pkg
interface ptb_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [ptb_pkg::VA_W-1:0]     virt_addr;
  logic [ptb_pkg::PA_W-1:0]     phys_addr;
  logic [ptb_pkg::LEN_W-1:0]    length;
  logic [ptb_pkg::FLG_W-1:0]    flags;
  modport source (output valid, req_type, virt_addr, phys_addr, length, flags, input ready);
  modport sink   (input valid, req_type, virt_addr, phys_addr, length, flags, output ready);
endinterface

interface ptb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ptb_pkg::ST_W-1:0]     status;
  logic [ptb_pkg::NFP_W-1:0]    pages_used;
  modport source (output valid, status, pages_used, input ready);
  modport sink   (input valid, status, pages_used, output ready);
endinterface

FILE: rtl/core/ptb_entry_eval.sv
// ptb_entry_eval: shared compare/subtract unit judging one table entry
// depends on ptb_pkg
module ptb_entry_eval #(
  parameter int POOL_PAGES = ptb_pkg::POOL_PAGES_DEF
) (
  input  logic [63:0]                 entry,
  input  logic [ptb_pkg::FRM_W-1:0]   base_frame,
  input  logic [ptb_pkg::FRM_W-1:0]   pa_frame,
  input  logic [1:0]                  lvl,
  input  logic                        large_op,
  output ptb_pkg::ptb_eval_t          verdict
);
  logic [ptb_pkg::FRM_W-1:0] diff;

  assign diff = entry[51:12] - base_frame;

  always_comb begin
    verdict.present = entry[ptb_pkg::E_PRESENT];
    verdict.refuse  = !large_op && (lvl == ptb_pkg::LVL_PD) && entry[ptb_pkg::E_LARGE];
    verdict.off_ok  = diff < ptb_pkg::FRM_W'(POOL_PAGES);
    verdict.off     = diff[ptb_pkg::OFF_W-1:0];
    // 2M leaf compares bits 51..21 and needs the size bit
    if (large_op) begin
      verdict.leaf_same = entry[ptb_pkg::E_LARGE] && (entry[51:21] == pa_frame[39:9]);
    end else begin
      verdict.leaf_same = (entry[51:12] == pa_frame);
    end
  end
endmodule

FILE: rtl/core/page_table_builder.sv
// page_table_builder: top level, sequencer, table store and config registers
// depends on ptb_pkg, ptb_req_if, ptb_rsp_if and ptb_entry_eval
//
// usage
//   in_req  : one beat per request (4K map, 2M map or range map)
//   out_rsp : one beat per request with status and pages in use
//   cfg_*   : pool_base (index 0) and pool_limit (index 1), written while idle
// timing
//   each table level is one registered read of the table store (S_RD), then
//   a pass through the shared entry evaluator (S_EVAL)
//   a 4K map walks down to the page table level, a 2M map stops at the PD level
//   each newly allocated table page adds a clear of the whole page through the
//   store write port (S_CLR_PG) plus the pointer write (S_WRP)
//   a range runs its page maps in turn, with S_NEXT picking each page step
//   one request is in flight at a time; in_req.ready is low meanwhile
// reset
//   after rst_n the whole store is cleared one entry a cycle with in_req.ready
//   low; config writes are taken during that pass
// stall
//   a finished result sits in the output register; a stalled out_rsp holds
//   the next result in the final state until the register frees
module page_table_builder #(
  parameter int POOL_PAGES = ptb_pkg::POOL_PAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ptb_req_if.sink                   in_req,
  ptb_rsp_if.source                 out_rsp,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ptb_pkg::PA_W-1:0]  cfg_data
);
  localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int AW    = PW + ptb_pkg::IDX_W;
  localparam int DEPTH = POOL_PAGES * 512;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [7:0] POOL8 = 8'(POOL_PAGES);

  typedef enum logic [2:0] {
    S_CLR_ALL, S_IDLE, S_NEXT, S_RD, S_EVAL, S_CLR_PG, S_WRP, S_FIN
  } state_t;

  typedef enum logic [1:0] {PH_HEAD, PH_BODY, PH_TAIL} phase_t;

  state_t                          state_r;
  phase_t                          phase_r;
  logic [ptb_pkg::VA_W-1:0]        va_r;
  logic [ptb_pkg::CUR_W-1:0]       pa_r, end_r;
  logic [ptb_pkg::FLG_W-1:0]       flags_r;
  logic                            range_r, large_r;
  logic [1:0]                      lvl_r;
  logic [PW-1:0]                   page_r, child_r;
  logic [AW-1:0]                   ctr_r;
  logic [ptb_pkg::NFP_W-1:0]       nfp_r;
  logic [ptb_pkg::PA_W-1:0]        base_r;
  logic [ptb_pkg::NFP_W-1:0]       limit_r;
  logic [ptb_pkg::ST_W-1:0]        status_r;
  logic                            out_valid_r;
  logic [ptb_pkg::ST_W-1:0]        out_status_r;
  logic [ptb_pkg::NFP_W-1:0]       out_pages_r;

  // table store
  logic [63:0]                     mem [DEPTH];
  logic [63:0]                     rdata_r;
  logic                            we;
  logic [AW-1:0]                   waddr, raddr;
  logic [63:0]                     wdata;

  logic [ptb_pkg::IDX_W-1:0]       idx;
  ptb_pkg::ptb_eval_t              verdict;
  logic                            is_leaf, pool_full;
  logic [7:0]                      cap8;
  logic [ptb_pkg::ST_W-1:0]        fail_st;
  logic [ptb_pkg::CUR_W-1:0]       step;
  logic                            small_cond;
  logic [63:0]                     ptr_entry, leaf_entry;
  logic [ptb_pkg::FRM_W-1:0]       ptr_frame;
  logic                            fin_load;

  // table index of the current level
  always_comb begin
    case (lvl_r)
      ptb_pkg::LVL_PML4: idx = va_r[47:39];
      ptb_pkg::LVL_PDPT: idx = va_r[38:30];
      ptb_pkg::LVL_PD:   idx = va_r[29:21];
      default:           idx = va_r[20:12];
    endcase
  end

  always_comb begin
    case (lvl_r)
      ptb_pkg::LVL_PML4: fail_st = ptb_pkg::ST_NO_PDPT;
      ptb_pkg::LVL_PDPT: fail_st = ptb_pkg::ST_NO_PD;
      default:           fail_st = ptb_pkg::ST_NO_PT;
    endcase
  end

  ptb_entry_eval #(.POOL_PAGES(POOL_PAGES)) u_eval (
    .entry      (rdata_r),
    .base_frame (base_r[51:12]),
    .pa_frame   (pa_r[51:12]),
    .lvl        (lvl_r),
    .large_op   (large_r),
    .verdict    (verdict)
  );

  assign is_leaf   = large_r ? (lvl_r == ptb_pkg::LVL_PD) : (lvl_r == ptb_pkg::LVL_PT);
  assign cap8      = ({3'd0, limit_r} < POOL8) ? {3'd0, limit_r} : POOL8;
  assign pool_full = {3'd0, nfp_r} >= cap8;
  assign step      = large_r ? ptb_pkg::CUR_W'(32'h0020_0000) : ptb_pkg::CUR_W'(32'h0000_1000);
  assign small_cond = (pa_r < end_r) && ((pa_r[20:0] | va_r[20:0]) != 21'd0);

  // result register loads from the final state once it is free
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_rsp.ready);

  // pointer to a pool page, wraps in the frame field
  assign ptr_frame = base_r[51:12] + ptb_pkg::FRM_W'(child_r);
  assign ptr_entry = {12'd0, ptr_frame, 10'd0, 2'b11};
  always_comb begin
    if (large_r) begin
      leaf_entry = {1'b1, 11'd0, pa_r[51:21], 9'd0, flags_r | 12'h081};
    end else begin
      leaf_entry = {1'b1, 11'd0, pa_r[51:12], flags_r | 12'h001};
    end
  end

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = {page_r, idx};
    wdata = leaf_entry;
    case (state_r)
      S_CLR_ALL: begin
        we    = 1'b1;
        waddr = ctr_r;
        wdata = 64'd0;
      end
      S_CLR_PG: begin
        we    = 1'b1;
        waddr = {child_r, ctr_r[ptb_pkg::IDX_W-1:0]};
        wdata = 64'd0;
      end
      S_WRP: begin
        we    = 1'b1;
        wdata = ptr_entry;
      end
      S_EVAL: begin
        we    = is_leaf && !verdict.present;
      end
      default: we = 1'b0;
    endcase
  end
  assign raddr = {page_r, idx};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign in_req.ready      = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.pages_used = out_pages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR_ALL;
      ctr_r       <= '0;
      nfp_r       <= ptb_pkg::NFP_W'(1);
      base_r      <= '0;
      limit_r     <= ptb_pkg::NFP_W'(16);
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEAD;
      range_r     <= 1'b0;
      large_r     <= 1'b0;
      lvl_r       <= ptb_pkg::LVL_PML4;
      page_r      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) begin
          base_r <= cfg_data;
        end else begin
          limit_r <= cfg_data[ptb_pkg::NFP_W-1:0];
        end
      end
      if (fin_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_pages_r  <= nfp_r;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR_ALL: begin
          ctr_r <= ctr_r + AW'(1);
          if (ctr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_req.valid) begin
            va_r     <= in_req.virt_addr;
            pa_r     <= ptb_pkg::CUR_W'(in_req.phys_addr);
            end_r    <= ptb_pkg::CUR_W'(in_req.phys_addr) + ptb_pkg::CUR_W'(in_req.length);
            flags_r  <= in_req.flags;
            page_r   <= '0;
            lvl_r    <= ptb_pkg::LVL_PML4;
            phase_r  <= PH_HEAD;
            range_r  <= (in_req.req_type == ptb_pkg::REQ_RANGE);
            case (in_req.req_type)
              ptb_pkg::REQ_4K: begin
                large_r  <= 1'b0;
                status_r <= ptb_pkg::ST_OK;
                state_r  <= S_RD;
              end
              ptb_pkg::REQ_2M: begin
                large_r <= 1'b1;
                if ((in_req.virt_addr[20:0] | in_req.phys_addr[20:0]) != 21'd0) begin
                  status_r <= ptb_pkg::ST_MISALIGNED;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= ptb_pkg::ST_OK;
                  state_r  <= S_RD;
                end
              end
              ptb_pkg::REQ_RANGE: begin
                status_r <= ptb_pkg::ST_OK;
                state_r  <= (in_req.length != '0) ? S_NEXT : S_FIN;
              end
              default: begin
                status_r <= ptb_pkg::ST_OK;
                state_r  <= S_FIN;
              end
            endcase
          end
        end

        // pick the next page of a range
        S_NEXT: begin
          page_r <= '0;
          lvl_r  <= ptb_pkg::LVL_PML4;
          case (phase_r)
            PH_HEAD: begin
              if (small_cond) begin
                large_r <= 1'b0;
                state_r <= S_RD;
              end else begin
                phase_r <= PH_BODY;
              end
            end
            PH_BODY: begin
              if (pa_r + ptb_pkg::CUR_W'(32'h0020_0000) <= end_r) begin
                large_r <= 1'b1;
                state_r <= S_RD;
              end else begin
                phase_r <= PH_TAIL;
              end
            end
            default: begin
              if (pa_r < end_r) begin
                large_r <= 1'b0;
                state_r <= S_RD;
              end else begin
                status_r <= ptb_pkg::ST_OK;
                state_r  <= S_FIN;
              end
            end
          endcase
        end

        S_RD: state_r <= S_EVAL;

        S_EVAL: begin
          if (is_leaf) begin
            if (verdict.present && !verdict.leaf_same) begin
              status_r <= ptb_pkg::ST_DIFFERENT;
              state_r  <= S_FIN;
            end else if (range_r) begin
              va_r    <= va_r + ptb_pkg::VA_W'(step);
              pa_r    <= pa_r + step;
              state_r <= S_NEXT;
            end else begin
              status_r <= ptb_pkg::ST_OK;
              state_r  <= S_FIN;
            end
          end else if (verdict.present) begin
            if (verdict.refuse || !verdict.off_ok) begin
              status_r <= fail_st;
              state_r  <= S_FIN;
            end else begin
              page_r  <= PW'(verdict.off);
              lvl_r   <= lvl_r - 2'd1;
              state_r <= S_RD;
            end
          end else if (pool_full) begin
            status_r <= fail_st;
            state_r  <= S_FIN;
          end else begin
            child_r <= PW'(nfp_r);
            nfp_r   <= nfp_r + ptb_pkg::NFP_W'(1);
            ctr_r   <= '0;
            state_r <= S_CLR_PG;
          end
        end

        // zero the new table page before linking it
        S_CLR_PG: begin
          ctr_r <= ctr_r + AW'(1);
          if (ctr_r[ptb_pkg::IDX_W-1:0] == '1) begin
            state_r <= S_WRP;
          end
        end

        S_WRP: begin
          page_r  <= child_r;
          lvl_r   <= lvl_r - 2'd1;
          state_r <= S_RD;
        end

        S_FIN: begin
          if (fin_load) begin
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // allocation never runs past the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {3'd0, nfp_r} <= POOL8)
    else $error("pool count past pool size");

  // an accepted request drops ready until it finishes
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("ready while request in flight");

  // a page allocation bumps the count by exactly one
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL && !is_leaf && !verdict.present && !pool_full
    |=> nfp_r == $past(nfp_r) + ptb_pkg::NFP_W'(1))
    else $error("allocation count slip");

  // a result is loaded only from the final state
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside final state");

  // a leaf write never lands on a pointer level
  a_leaf_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL && we |-> (lvl_r == ptb_pkg::LVL_PT || lvl_r == ptb_pkg::LVL_PD))
    else $error("leaf write on pointer level");

endmodule
